### rtl/nnt_pkg.sv
// nnt_pkg: shared sizes, payload structs and control struct for the
// nearest neighbor tour core. no dependencies.
package nnt_pkg;

  localparam int MAX_NODES = 64;
  localparam int NODE_BITS = $clog2(MAX_NODES);
  localparam int CNT_BITS  = NODE_BITS + 1;
  localparam int DIST_BITS = 24;
  localparam int LEN_BITS  = 32;
  localparam int ADDR_BITS = 2 * NODE_BITS;

  localparam logic [CNT_BITS-1:0] MIN_CNT   = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0] MAX_CNT   = CNT_BITS'(MAX_NODES);
  localparam logic [CNT_BITS-1:0] RESET_CNT = CNT_BITS'(64);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_RUN   = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [NODE_BITS-1:0] row_node;
    logic [NODE_BITS-1:0] col_node;
    logic [DIST_BITS-1:0] distance;
  } in_item_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] tour_node;
    logic [LEN_BITS-1:0]  tour_length;
    logic                 last;
  } out_item_t;

  // run request from the front end to the sequencer
  typedef struct packed {
    logic                start;
    logic [CNT_BITS-1:0] node_cnt;
  } run_req_t;

endpackage

### rtl/nearest_neighbor_tour_core.sv
// nearest_neighbor_tour_core: top level, request decode, node count
// register, distance matrix. depends on nnt_pkg, nnt_dist_mem, nnt_ctrl.
//
//   channel  direction  payload              handshake
//   in_      input      nnt_pkg::in_item_t   in_valid / in_ready
//   out_     output     nnt_pkg::out_item_t  out_valid / out_ready
//   cfg_     input      node_count (7 bits)  cfg_valid / cfg_ready
//
// a write request is taken without leaving idle; in_ready stays high between runs.
// a run request with n cities runs one scan per position i < n-2 in the
// single compare unit, then reads the closing edges, then emits each
// result, waiting out any out_ready stall.
// in_ready is low for the whole run. reset clears control state only; the
// distance matrix holds garbage until written, tour order restarts per run.
module nearest_neighbor_tour_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  nnt_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output nnt_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [nnt_pkg::CNT_BITS-1:0] cfg_data
);
  import nnt_pkg::*;

  logic [CNT_BITS-1:0]  node_count_r;
  logic [CNT_BITS-1:0]  node_cnt_eff;
  logic                 busy;
  logic                 in_take;
  logic [ADDR_BITS-1:0] dist_rd_addr;
  logic [DIST_BITS-1:0] dist_rd_data;
  run_req_t             req;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign in_take   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= RESET_CNT;
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_data;
    end
  end

  always_comb begin
    priority if (node_count_r < MIN_CNT) begin
      node_cnt_eff = MIN_CNT;
    end else if (node_count_r > MAX_CNT) begin
      node_cnt_eff = MAX_CNT;
    end else begin
      node_cnt_eff = node_count_r;
    end
  end

  assign req.start    = in_take && (in_data.command == CMD_RUN);
  assign req.node_cnt = node_cnt_eff;

  nnt_dist_mem u_dist_mem (
    .clk     (clk),
    .wr_en   (in_take && (in_data.command == CMD_WRITE)),
    .wr_addr ({in_data.row_node, in_data.col_node}),
    .wr_data (in_data.distance),
    .rd_addr (dist_rd_addr),
    .rd_data (dist_rd_data)
  );

  nnt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .busy         (busy),
    .dist_rd_addr (dist_rd_addr),
    .dist_rd_data (dist_rd_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

`ifndef SYNTHESIS
  // results only come out of a run, never while requests are taken
  a_no_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("in_ready high while a result is pending");

  // a run request locks out further requests on the next cycle
  a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_RUN) |=> !in_ready)
    else $error("run request did not start the sequencer");

  // a write request leaves the block idle
  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.command == CMD_WRITE) |=> in_ready)
    else $error("write request started a run");

  // length rides only on the final city
  a_len_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> (out_data.tour_length == '0))
    else $error("tour length on a non-final result");
`endif

endmodule

### rtl/nnt_dist_mem.sv
// nnt_dist_mem: distance matrix storage, one write and one registered read
// per cycle. depends on nnt_pkg.
module nnt_dist_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [nnt_pkg::ADDR_BITS-1:0] wr_addr,
  input  logic [nnt_pkg::DIST_BITS-1:0] wr_data,
  input  logic [nnt_pkg::ADDR_BITS-1:0] rd_addr,
  output logic [nnt_pkg::DIST_BITS-1:0] rd_data
);
  import nnt_pkg::*;

  logic [DIST_BITS-1:0] mem [MAX_NODES*MAX_NODES];
  logic [DIST_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/nnt_tour_mem.sv
// nnt_tour_mem: tour order storage with per-entry valid bits; an entry not
// written since the last clear reads as its own index. depends on nnt_pkg.
module nnt_tour_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  logic                          wr_en,
  input  logic [nnt_pkg::NODE_BITS-1:0] wr_addr,
  input  logic [nnt_pkg::NODE_BITS-1:0] wr_data,
  input  logic [nnt_pkg::NODE_BITS-1:0] rd_addr,
  output logic [nnt_pkg::NODE_BITS-1:0] rd_node
);
  import nnt_pkg::*;

  logic [NODE_BITS-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] valid_r;
  logic [NODE_BITS-1:0] rd_data_r;
  logic [NODE_BITS-1:0] rd_addr_r;
  logic                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clear) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r  <= mem[rd_addr];
    rd_addr_r  <= rd_addr;
    rd_valid_r <= valid_r[rd_addr];
  end

  // identity order until an entry is swapped
  assign rd_node = rd_valid_r ? rd_data_r : rd_addr_r;

endmodule

### rtl/nnt_ctrl.sv
// nnt_ctrl: run sequencer with the shared compare/accumulate unit, tour
// order memory and result register. depends on nnt_pkg, nnt_tour_mem.
module nnt_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nnt_pkg::run_req_t             req,
  output logic                          busy,
  output logic [nnt_pkg::ADDR_BITS-1:0] dist_rd_addr,
  input  logic [nnt_pkg::DIST_BITS-1:0] dist_rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output nnt_pkg::out_item_t            out_data
);
  import nnt_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b00000000001,
    ST_SCAN    = 11'b00000000010,
    ST_SWAP1   = 11'b00000000100,
    ST_SWAP2   = 11'b00000001000,
    ST_TAIL0   = 11'b00000010000,
    ST_TAIL1   = 11'b00000100000,
    ST_TAIL2   = 11'b00001000000,
    ST_TAIL3   = 11'b00010000000,
    ST_EMIT_RD = 11'b00100000000,
    ST_EMIT_LD = 11'b01000000000,
    ST_EMIT    = 11'b10000000000
  } state_t;

  function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                  input logic [DIST_BITS-1:0] b);
    logic [LEN_BITS:0] sum;
    sum = {1'b0, a} + (LEN_BITS+1)'(b);
    return sum[LEN_BITS] ? '1 : sum[LEN_BITS-1:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [NODE_BITS-1:0] i_r, i_nxt;
  logic [NODE_BITS-1:0] cur_r, cur_nxt;
  logic [CNT_BITS-1:0]  v_iss_r, v_iss_nxt;
  logic [CNT_BITS-1:0]  n_r, n_nxt;
  logic [NODE_BITS-1:0] k_r, k_nxt;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s2_valid_r, s2_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [NODE_BITS-1:0] s1_pos_r, s1_pos_nxt;
  logic [NODE_BITS-1:0] s2_pos_r, s2_pos_nxt;
  logic [NODE_BITS-1:0] s2_node_r, s2_node_nxt;
  logic [DIST_BITS-1:0] best_r, best_nxt;
  logic [NODE_BITS-1:0] best_pos_r, best_pos_nxt;
  logic [NODE_BITS-1:0] best_node_r, best_node_nxt;
  logic [NODE_BITS-1:0] first_node_r, first_node_nxt;
  logic [NODE_BITS-1:0] last_node_r, last_node_nxt;
  logic [LEN_BITS-1:0]  len_r, len_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 tour_clear;
  logic                 tour_wr_en;
  logic [NODE_BITS-1:0] tour_wr_addr;
  logic [NODE_BITS-1:0] tour_wr_data;
  logic [NODE_BITS-1:0] tour_rd_addr;
  logic [NODE_BITS-1:0] tour_rd_node;

  logic [CNT_BITS-1:0]  i_plus1;
  logic [NODE_BITS-1:0] n_last;
  logic                 k_is_last;

  assign i_plus1   = {1'b0, i_r} + CNT_BITS'(1);
  assign n_last    = NODE_BITS'(n_r - CNT_BITS'(1));
  assign k_is_last = (k_r == n_last);

  nnt_tour_mem u_tour_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (tour_clear),
    .wr_en   (tour_wr_en),
    .wr_addr (tour_wr_addr),
    .wr_data (tour_wr_data),
    .rd_addr (tour_rd_addr),
    .rd_node (tour_rd_node)
  );

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    cur_nxt        = cur_r;
    v_iss_nxt      = v_iss_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    best_nxt       = best_r;
    best_pos_nxt   = best_pos_r;
    best_node_nxt  = best_node_r;
    first_node_nxt = first_node_r;
    last_node_nxt  = last_node_r;
    len_nxt        = len_r;
    tour_clear     = 1'b0;
    tour_wr_en     = 1'b0;
    tour_wr_addr   = best_pos_r;
    tour_wr_data   = first_node_r;
    tour_rd_addr   = v_iss_r[NODE_BITS-1:0];
    dist_rd_addr   = {cur_r, tour_rd_node};

    // scan pipeline: tour read, then distance read, then compare
    s1_valid_nxt = (state_r == ST_SCAN) && (v_iss_r < n_r);
    s1_pos_nxt   = v_iss_r[NODE_BITS-1:0];
    s2_valid_nxt = s1_valid_r;
    s2_pos_nxt   = s1_pos_r;
    s2_node_nxt  = tour_rd_node;

    unique case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          n_nxt      = req.node_cnt;
          i_nxt      = '0;
          cur_nxt    = '0;
          len_nxt    = '0;
          v_iss_nxt  = CNT_BITS'(1);
          tour_clear = 1'b1;
          state_nxt  = (req.node_cnt > MIN_CNT) ? ST_SCAN : ST_TAIL0;
        end
      end
      ST_SCAN: begin
        if (v_iss_r < n_r) begin
          v_iss_nxt = v_iss_r + CNT_BITS'(1);
        end
        if (s2_valid_r) begin
          // first candidate seeds the minimum, strict less keeps earliest
          if (s2_pos_r == i_plus1[NODE_BITS-1:0]) begin
            best_nxt       = dist_rd_data;
            best_pos_nxt   = s2_pos_r;
            best_node_nxt  = s2_node_r;
            first_node_nxt = s2_node_r;
          end else if (dist_rd_data < best_r) begin
            best_nxt      = dist_rd_data;
            best_pos_nxt  = s2_pos_r;
            best_node_nxt = s2_node_r;
          end
          if (s2_pos_r == n_last) begin
            state_nxt = ST_SWAP1;
          end
        end
      end
      ST_SWAP1: begin
        tour_wr_en   = 1'b1;
        tour_wr_addr = best_pos_r;
        tour_wr_data = first_node_r;
        state_nxt    = ST_SWAP2;
      end
      ST_SWAP2: begin
        // written second so it wins when best_pos is i+1
        tour_wr_en   = 1'b1;
        tour_wr_addr = i_plus1[NODE_BITS-1:0];
        tour_wr_data = best_node_r;
        len_nxt      = sat_add(len_r, best_r);
        cur_nxt      = best_node_r;
        i_nxt        = i_plus1[NODE_BITS-1:0];
        if ({1'b0, i_r} + CNT_BITS'(3) < n_r) begin
          v_iss_nxt = {1'b0, i_r} + CNT_BITS'(2);
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_TAIL0;
        end
      end
      ST_TAIL0: begin
        tour_rd_addr = n_last;
        state_nxt    = ST_TAIL1;
      end
      ST_TAIL1: begin
        last_node_nxt = tour_rd_node;
        dist_rd_addr  = {cur_r, tour_rd_node};
        state_nxt     = ST_TAIL2;
      end
      ST_TAIL2: begin
        // closing edge back to the start city, which never moves
        dist_rd_addr = {last_node_r, NODE_BITS'(0)};
        len_nxt      = sat_add(len_r, dist_rd_data);
        state_nxt    = ST_TAIL3;
      end
      ST_TAIL3: begin
        len_nxt   = sat_add(len_r, dist_rd_data);
        k_nxt     = '0;
        state_nxt = ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        tour_rd_addr = k_r;
        state_nxt    = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_data_nxt.tour_node   = tour_rd_node;
        out_data_nxt.tour_length = k_is_last ? len_r : '0;
        out_data_nxt.last        = k_is_last;
        out_valid_nxt            = 1'b1;
        state_nxt                = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (k_is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + NODE_BITS'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      v_iss_r     <= '0;
      n_r         <= MIN_CNT;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      i_r         <= i_nxt;
      v_iss_r     <= v_iss_nxt;
      n_r         <= n_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    s1_pos_r     <= s1_pos_nxt;
    s2_pos_r     <= s2_pos_nxt;
    s2_node_r    <= s2_node_nxt;
    best_r       <= best_nxt;
    best_pos_r   <= best_pos_nxt;
    best_node_r  <= best_node_nxt;
    first_node_r <= first_node_nxt;
    last_node_r  <= last_node_nxt;
    len_r        <= len_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### test/nearest_neighbor_tour_core_tb.sv
// nearest_neighbor_tour_core_tb: self-checking bench for the nearest neighbor tour core.
// predicts every emitted tour from its own copy of the distance matrix and node count.
// depends on nnt_pkg and nearest_neighbor_tour_core.
module nearest_neighbor_tour_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nnt_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 64;
  localparam int RUN_LIMIT_NS  = 8_000_000;
  localparam int PRINT_LIMIT   = 100;

  typedef enum {DIST_WIDE, DIST_TIES, DIST_EXTREME} dist_style_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CNT_BITS-1:0] cfg_data;

  // bench copy of the block state
  logic [DIST_BITS-1:0] dist_copy [MAX_NODES][MAX_NODES];
  logic [CNT_BITS-1:0]  node_count_copy = RESET_CNT;
  out_item_t            pending_tour [$];

  int          mismatches     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;
  dist_style_t dist_style     = DIST_WIDE;

  nearest_neighbor_tour_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) $display("mismatch: %s", what);
    mismatches++;
  endtask

  function automatic int clamp_count(input logic [CNT_BITS-1:0] value);
    if (value < MIN_CNT) return int'(MIN_CNT);
    if (value > MAX_CNT) return int'(MAX_CNT);
    return int'(value);
  endfunction

  // greedy tour from the identity order, then the closed length
  function automatic void predict_tour();
    int                   order [MAX_NODES];
    int                   n;
    int                   best_pos;
    int                   swap;
    logic [DIST_BITS-1:0] best;
    logic [63:0]          len;
    out_item_t            res;
    n = clamp_count(node_count_copy);
    for (int k = 0; k < MAX_NODES; k++) order[k] = k;
    for (int i = 0; i + 2 < n; i++) begin
      best_pos = i + 1;
      best = dist_copy[order[i]][order[i + 1]];
      for (int v = i + 2; v < n; v++) begin
        // strict compare keeps the first position on a tie
        if (dist_copy[order[i]][order[v]] < best) begin
          best = dist_copy[order[i]][order[v]];
          best_pos = v;
        end
      end
      swap = order[i + 1];
      order[i + 1] = order[best_pos];
      order[best_pos] = swap;
    end
    len = '0;
    for (int k = 0; k < n; k++) begin
      len += dist_copy[order[k]][order[(k + 1) % n]];
      if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
    end
    for (int k = 0; k < n; k++) begin
      res.tour_node   = NODE_BITS'(order[k]);
      res.last        = (k == n - 1);
      res.tour_length = res.last ? len[LEN_BITS-1:0] : '0;
      pending_tour.push_back(res);
    end
  endfunction

  // result check first, then requests accepted at this edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      node_count_copy = RESET_CNT;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_tour.size() == 0) begin
          report_mismatch($sformatf("unexpected result, node %0d last %0b",
                                    out_data.tour_node, out_data.last));
        end else begin
          want = pending_tour.pop_front();
          if (out_data.tour_node !== want.tour_node)
            report_mismatch($sformatf("tour_node %0d, want %0d",
                                      out_data.tour_node, want.tour_node));
          if (out_data.tour_length !== want.tour_length)
            report_mismatch($sformatf("tour_length %0d, want %0d",
                                      out_data.tour_length, want.tour_length));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", out_data.last, want.last));
        end
      end
      if (cfg_valid && cfg_ready) node_count_copy = cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.command == CMD_WRITE)
          dist_copy[in_data.row_node][in_data.col_node] = in_data.distance;
        else
          predict_tour();
      end
    end
  end

  // result side: random stalls, or a counted hold-off when one is requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [DIST_BITS-1:0] pick_distance();
    case (dist_style)
      DIST_TIES: return DIST_BITS'($urandom_range(0, 3));
      DIST_EXTREME: begin
        case ($urandom_range(3))
          0: return '0;
          1: return '1;
          2: return '1 - 1'b1;
          default: return DIST_BITS'($urandom);
        endcase
      end
      default: return DIST_BITS'($urandom);
    endcase
  endfunction

  task automatic wait_for_results();
    while (pending_tour.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_request(input logic cmd, input int row, input int col,
                              input logic [DIST_BITS-1:0] dist_val);
    in_item_t req;
    req.command  = cmd;
    req.row_node = NODE_BITS'(row);
    req.col_node = NODE_BITS'(col);
    req.distance = dist_val;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_pair(input int a, input int b, input logic [DIST_BITS-1:0] dist_val);
    send_request(CMD_WRITE, a, b, dist_val);
    if (a != b) send_request(CMD_WRITE, b, a, dist_val);
  endtask

  task automatic start_run();
    send_request(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
                 DIST_BITS'($urandom));
  endtask

  // every entry among the first n cities, diagonal included
  task automatic load_pairs(input int n);
    for (int a = 0; a < n; a++)
      for (int b = a; b < n; b++) write_pair(a, b, pick_distance());
  endtask

  task automatic set_node_count(input logic [CNT_BITS-1:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // reset count of 64 over a fully loaded matrix, one asymmetric extreme edge
  task automatic test_full_matrix();
    dist_style = DIST_WIDE;
    load_pairs(MAX_NODES);
    send_request(CMD_WRITE, 0, 1, '1);
    send_request(CMD_WRITE, 1, 0, '0);
    start_run();
  endtask

  task automatic test_count_floor();
    logic [CNT_BITS-1:0] counts [3] = '{0, 1, 2};
    foreach (counts[k]) begin
      set_node_count(counts[k]);
      start_run();
    end
  endtask

  task automatic test_count_ceiling();
    logic [CNT_BITS-1:0] counts [3] = '{127, 65, 64};
    foreach (counts[k]) begin
      set_node_count(counts[k]);
      start_run();
    end
  endtask

  task automatic test_ties();
    set_node_count(7);
    for (int a = 0; a < 7; a++)
      for (int b = 0; b < 7; b++) send_request(CMD_WRITE, a, b, 5);
    // all equal: order stays identity
    start_run();
    // two equal minima from city 0, the earlier position wins
    send_request(CMD_WRITE, 0, 3, 1);
    send_request(CMD_WRITE, 0, 5, 1);
    start_run();
  endtask

  // long result hold-off while runs keep coming, then a full drain
  task automatic test_back_pressure();
    set_node_count(5);
    hold_left = 400;
    repeat (4) start_run();
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                     input int count, input dist_style_t style,
                                     input int n_items);
    int n;
    int pick;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    set_node_count(CNT_BITS'(count));
    n = clamp_count(CNT_BITS'(count));
    dist_style = style;
    load_pairs(n);
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < 30)
        start_run();
      else if (pick < 80)
        write_pair($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_distance());
      else
        send_request(CMD_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                     pick_distance());
    end
    wait_for_results();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_full_matrix();
    test_count_floor();
    test_count_ceiling();
    test_ties();
    test_back_pressure();
    test_random_traffic(0, 0, $urandom_range(0, 12), DIST_TIES, 30);
    test_random_traffic(59, 0, $urandom_range(2, 24), DIST_WIDE, 30);
    test_random_traffic(0, 59, $urandom_range(3, 16), DIST_EXTREME, 30);
    test_random_traffic(13, 13, $urandom_range(65, 127), DIST_WIDE, 30);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_tour.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
